// ===== rtl/tsfmr_pkg.sv =====
// ----------------------------------------------------------------------------
// tsfmr_pkg
// shared types and constants of the touch sample filter, map and rotate core
// ----------------------------------------------------------------------------
package tsfmr_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int RAW_W        = 12;
  localparam int PRESS_W      = 13;
  localparam int ROT_W        = 2;
  localparam int COORD_W      = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESSURE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MAX     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NATIVE_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NATIVE_HEIGHT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION      = 3'd7;

  // rotation codes
  localparam logic [ROT_W-1:0] ROT_NONE = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90   = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180  = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270  = 2'd3;

  // reset values
  localparam logic [PRESS_W-1:0] MIN_PRESSURE_RST  = 13'd0;
  localparam logic [RAW_W-1:0]   RAW_MIN_RST       = 12'd0;
  localparam logic [RAW_W-1:0]   RAW_MAX_RST       = 12'd4095;
  localparam logic [RAW_W-1:0]   NATIVE_WIDTH_RST  = 12'd320;
  localparam logic [RAW_W-1:0]   NATIVE_HEIGHT_RST = 12'd240;

  typedef struct packed {
    logic [PRESS_W-1:0] min_pressure;
    logic [RAW_W-1:0]   x_raw_min;
    logic [RAW_W-1:0]   x_raw_max;
    logic [RAW_W-1:0]   y_raw_min;
    logic [RAW_W-1:0]   y_raw_max;
    logic [RAW_W-1:0]   native_width;
    logic [RAW_W-1:0]   native_height;
    logic [ROT_W-1:0]   rotation;
  } cfg_t;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/touch_sample_filter_map_rotate_core.sv =====
// ----------------------------------------------------------------------------
// touch_sample_filter_map_rotate_core
// resistive touch sample filter, calibration map and quarter-turn rotation
// ----------------------------------------------------------------------------
// usage
//   in_* channel: one sample set per transfer (pen level, z1/z2, three x and
//   three y conversions). out_* channel: one result per sample set with the
//   touched flag, rotated coordinates (-1 when not touched) and the flag of
//   the preceding sample. both channels are valid/ready.
//   cfg_* port: write enable, register index and data; write only while idle.
// throughput
//   one sample set at a time; in_ready is high only while the sequencer idles.
//   a touched sample walks each axis through one shared restoring divider of
//   NUM_W = max(ADC_BITS,12)+12 steps, unless that axis has a zero-width raw
//   range. an untouched sample skips the mapping and goes straight to output.
// reset
//   synchronous active-low reset loads the register defaults, clears the
//   previous-touch flag and drops out_valid.
// stall
//   a finished result sits in the output register; the next sample may be
//   accepted meanwhile, and its result waits until the held one transfers.
// ----------------------------------------------------------------------------
module touch_sample_filter_map_rotate_core #(
  parameter int ADC_BITS = tsfmr_pkg::ADC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration port
  input  logic                                cfg_we,
  input  logic [tsfmr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsfmr_pkg::CFG_DATA_W-1:0]    cfg_data,
  // sample input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_pen_released,
  input  logic [ADC_BITS-1:0]                 in_pressure_first,
  input  logic [ADC_BITS-1:0]                 in_pressure_second,
  input  logic [ADC_BITS-1:0]                 in_x_sample_a,
  input  logic [ADC_BITS-1:0]                 in_x_sample_b,
  input  logic [ADC_BITS-1:0]                 in_x_sample_c,
  input  logic [ADC_BITS-1:0]                 in_y_sample_a,
  input  logic [ADC_BITS-1:0]                 in_y_sample_b,
  input  logic [ADC_BITS-1:0]                 in_y_sample_c,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_touched,
  output logic signed [tsfmr_pkg::COORD_W-1:0] out_pos_x,
  output logic signed [tsfmr_pkg::COORD_W-1:0] out_pos_y,
  output logic                                out_was_touched
);
  import tsfmr_pkg::*;

  // magnitude width of a raw value, of the product and of the pressure sum
  localparam int MAG_W = (ADC_BITS > RAW_W) ? ADC_BITS : RAW_W;
  localparam int NUM_W = MAG_W + RAW_W;
  localparam int PW    = ((ADC_BITS + 1) > PRESS_W) ? (ADC_BITS + 1) : PRESS_W;
  localparam logic [PW-1:0] ADC_MAX_P = PW'((1 << ADC_BITS) - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MEAN  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_FIX   = 3'd5;
  localparam logic [2:0] ST_ROT   = 3'd6;

  // mean of the two closest readings, ties prefer (a,b) then (a,c)
  function automatic logic [ADC_BITS-1:0] pair_mean(
    input logic [ADC_BITS-1:0] a,
    input logic [ADC_BITS-1:0] b,
    input logic [ADC_BITS-1:0] c
  );
    logic [ADC_BITS-1:0] dab;
    logic [ADC_BITS-1:0] dac;
    logic [ADC_BITS-1:0] dbc;
    logic [ADC_BITS:0]   sum;
    dab = (a > b) ? a - b : b - a;
    dac = (a > c) ? a - c : c - a;
    dbc = (b > c) ? b - c : c - b;
    if (dab <= dac && dab <= dbc) begin
      sum = {1'b0, a} + {1'b0, b};
    end else if (dac <= dbc) begin
      sum = {1'b0, a} + {1'b0, c};
    end else begin
      sum = {1'b0, b} + {1'b0, c};
    end
    return sum[ADC_BITS:1];
  endfunction

  cfg_t cfg_r;

  logic [2:0]          state_r;
  logic [2:0]          state_nxt;
  logic                axis_r;          // 0 while x is worked, 1 for y
  logic                hit_r;
  logic                last_touched_r;
  logic                was_r;

  logic [ADC_BITS-1:0] xa_r, xb_r, xc_r, ya_r, yb_r, yc_r;

  // per-axis working registers
  logic [MAG_W-1:0]    diff_mag_r;
  logic                diff_neg_r;
  logic [RAW_W-1:0]    den_mag_r;
  logic                den_neg_r;
  logic [RAW_W-1:0]    last_mag_r;
  logic                last_neg_r;
  logic [RAW_W-1:0]    last_pos_r;
  logic [NUM_W-1:0]    prod_r;
  logic                prod_neg_r;

  logic signed [COORD_W-1:0] nx_r, ny_r;

  logic                out_valid_r;
  logic                out_touched_r;
  logic                out_was_r;
  logic signed [COORD_W-1:0] out_x_r, out_y_r;

  // combinational helpers
  logic                in_xfer;
  logic                out_load;
  logic [PW-1:0]       pressure;
  logic                hit_now;
  logic [ADC_BITS-1:0] mean_v;
  logic [RAW_W-1:0]    lo_sel, hi_sel, size_sel;
  logic [MAG_W:0]      diff_s;
  logic [RAW_W:0]      den_s;
  logic [COORD_W-1:0]  last_s;
  logic [NUM_W-1:0]    div_quo;
  div_stat_t           div_stat;
  logic                q_neg;
  logic signed [COORD_W-1:0] nat_v;
  logic signed [COORD_W-1:0] wl, hl;
  logic signed [COORD_W-1:0] rot_x, rot_y;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state_r == ST_ROT) && (!out_valid_r || out_ready);

  // pressure is z1 + full scale - z2, never negative
  assign pressure = PW'(in_pressure_first) + ADC_MAX_P - PW'(in_pressure_second);
  assign hit_now  = !in_pen_released && (pressure >= PW'(cfg_r.min_pressure));

  // axis selection for the shared datapath
  always_comb begin
    if (axis_r) begin
      mean_v   = pair_mean(ya_r, yb_r, yc_r);
      lo_sel   = cfg_r.y_raw_min;
      hi_sel   = cfg_r.y_raw_max;
      size_sel = cfg_r.native_height;
    end else begin
      mean_v   = pair_mean(xa_r, xb_r, xc_r);
      lo_sel   = cfg_r.x_raw_min;
      hi_sel   = cfg_r.x_raw_max;
      size_sel = cfg_r.native_width;
    end
  end

  assign diff_s = (MAG_W + 1)'(mean_v) - (MAG_W + 1)'(lo_sel);
  assign den_s  = {1'b0, hi_sel} - {1'b0, lo_sel};
  assign last_s = {1'b0, size_sel} - 1'b1;

  tsfmr_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_START),
    .num   (prod_r),
    .den   (den_mag_r),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // truncated quotient sign, then clamp into the axis range
  assign q_neg = (prod_neg_r ^ den_neg_r) && (div_quo != '0);

  always_comb begin
    if (last_neg_r) begin
      // zero panel size: range is -1..0
      nat_v = q_neg ? -COORD_W'(1) : '0;
    end else if (q_neg) begin
      nat_v = '0;
    end else if (div_quo > NUM_W'(last_pos_r)) begin
      nat_v = COORD_W'(last_pos_r);
    end else begin
      nat_v = COORD_W'(div_quo);
    end
  end

  // quarter-turn rotation, wrapped to the coordinate width
  assign wl = COORD_W'({1'b0, cfg_r.native_width}) - 1'b1;
  assign hl = COORD_W'({1'b0, cfg_r.native_height}) - 1'b1;

  always_comb begin
    case (cfg_r.rotation)
      ROT_NONE: begin
        rot_x = nx_r;
        rot_y = ny_r;
      end
      ROT_90: begin
        rot_x = hl - ny_r;
        rot_y = nx_r;
      end
      ROT_180: begin
        rot_x = wl - nx_r;
        rot_y = hl - ny_r;
      end
      default: begin
        rot_x = ny_r;
        rot_y = wl - nx_r;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = hit_now ? ST_MEAN : ST_ROT;
      ST_MEAN: begin
        if (den_s == '0) state_nxt = axis_r ? ST_ROT : ST_MEAN;
        else             state_nxt = ST_MUL;
      end
      ST_MUL:   state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV:   if (div_stat.done) state_nxt = ST_FIX;
      ST_FIX:   state_nxt = axis_r ? ST_ROT : ST_MEAN;
      ST_ROT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      axis_r         <= 1'b0;
      hit_r          <= 1'b0;
      last_touched_r <= 1'b0;
      was_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        axis_r         <= 1'b0;
        hit_r          <= hit_now;
        was_r          <= last_touched_r;
        last_touched_r <= hit_now;
      end
      if ((state_r == ST_MEAN && den_s == '0) || state_r == ST_FIX) begin
        axis_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_pressure  <= MIN_PRESSURE_RST;
      cfg_r.x_raw_min     <= RAW_MIN_RST;
      cfg_r.x_raw_max     <= RAW_MAX_RST;
      cfg_r.y_raw_min     <= RAW_MIN_RST;
      cfg_r.y_raw_max     <= RAW_MAX_RST;
      cfg_r.native_width  <= NATIVE_WIDTH_RST;
      cfg_r.native_height <= NATIVE_HEIGHT_RST;
      cfg_r.rotation      <= ROT_NONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_PRESSURE:  cfg_r.min_pressure  <= cfg_data[PRESS_W-1:0];
        REG_X_RAW_MIN:     cfg_r.x_raw_min     <= cfg_data[RAW_W-1:0];
        REG_X_RAW_MAX:     cfg_r.x_raw_max     <= cfg_data[RAW_W-1:0];
        REG_Y_RAW_MIN:     cfg_r.y_raw_min     <= cfg_data[RAW_W-1:0];
        REG_Y_RAW_MAX:     cfg_r.y_raw_max     <= cfg_data[RAW_W-1:0];
        REG_NATIVE_WIDTH:  cfg_r.native_width  <= cfg_data[RAW_W-1:0];
        REG_NATIVE_HEIGHT: cfg_r.native_height <= cfg_data[RAW_W-1:0];
        REG_ROTATION:      cfg_r.rotation      <= cfg_data[ROT_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      xa_r <= in_x_sample_a;
      xb_r <= in_x_sample_b;
      xc_r <= in_x_sample_c;
      ya_r <= in_y_sample_a;
      yb_r <= in_y_sample_b;
      yc_r <= in_y_sample_c;
    end
    if (state_r == ST_MEAN) begin
      diff_neg_r <= diff_s[MAG_W];
      diff_mag_r <= diff_s[MAG_W] ? MAG_W'(-diff_s) : diff_s[MAG_W-1:0];
      den_neg_r  <= den_s[RAW_W];
      den_mag_r  <= den_s[RAW_W] ? RAW_W'(-den_s) : den_s[RAW_W-1:0];
      last_neg_r <= last_s[COORD_W-1];
      last_mag_r <= last_s[COORD_W-1] ? RAW_W'(1) : last_s[RAW_W-1:0];
      last_pos_r <= last_s[RAW_W-1:0];
      if (den_s == '0) begin
        // zero-width raw range maps to column or row zero
        if (axis_r) ny_r <= '0;
        else        nx_r <= '0;
      end
    end
    if (state_r == ST_MUL) begin
      prod_r     <= NUM_W'(diff_mag_r) * NUM_W'(last_mag_r);
      prod_neg_r <= diff_neg_r ^ last_neg_r;
    end
    if (state_r == ST_FIX) begin
      if (axis_r) ny_r <= nat_v;
      else        nx_r <= nat_v;
    end
    if (out_load) begin
      out_touched_r <= hit_r;
      out_was_r     <= was_r;
      out_x_r       <= hit_r ? rot_x : -COORD_W'(1);
      out_y_r       <= hit_r ? rot_y : -COORD_W'(1);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_touched     = out_touched_r;
  assign out_was_touched = out_was_r;
  assign out_pos_x       = out_x_r;
  assign out_pos_y       = out_y_r;

endmodule

// ===== rtl/tsfmr_div.sv =====
// ----------------------------------------------------------------------------
// tsfmr_div
// restoring divider, one quotient bit per cycle, shared by both axes
// ----------------------------------------------------------------------------
module tsfmr_div #(
  parameter int NUM_W = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [NUM_W-1:0]           num,
  input  logic [tsfmr_pkg::RAW_W-1:0] den,
  output logic [NUM_W-1:0]           quo,
  output tsfmr_pkg::div_stat_t       stat
);
  import tsfmr_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [RAW_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [RAW_W:0]   trial;
  logic [RAW_W:0]   trial_sub;
  logic             trial_ge;

  assign trial     = {rem_r, quo_r[NUM_W-1]};
  assign trial_ge  = trial >= {1'b0, den};
  assign trial_sub = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= trial_ge ? trial_sub[RAW_W-1:0] : trial[RAW_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], trial_ge};
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== tb/touch_sample_filter_map_rotate_core_test.sv =====
// ----------------------------------------------------------------------------
// touch_sample_filter_map_rotate_core_test
// self-checking bench for the touch filter, calibration map and rotation core:
// a directed table of sample sets and register writes, then random phases,
// each with its own register setting. every transfer on the result channel is
// compared field by field with the oldest expected result, from the bench model
// or typed into the directed table row
module touch_sample_filter_map_rotate_core_test;
  import tsfmr_pkg::*;

  localparam int ADC_MAX         = (1 << RAW_W) - 1;
  localparam int RESET_CYCLES    = 9;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 113;
  localparam int HOLD_PHASE      = 3;     // phase with the long result hold-off
  localparam int PAUSE_PHASE     = 5;     // phase with a mid-phase drain
  localparam int LONG_HOLD       = 400;
  localparam int DRAIN_CYCLES    = 100;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int MAX_REPORTS     = 10;

  // one sample set as it crosses the input channel
  typedef struct {
    logic             pen_released;
    logic [RAW_W-1:0] pressure_first;
    logic [RAW_W-1:0] pressure_second;
    logic [RAW_W-1:0] x_sample_a;
    logic [RAW_W-1:0] x_sample_b;
    logic [RAW_W-1:0] x_sample_c;
    logic [RAW_W-1:0] y_sample_a;
    logic [RAW_W-1:0] y_sample_b;
    logic [RAW_W-1:0] y_sample_c;
  } touch_sample_t;

  // one result as it crosses the output channel
  typedef struct {
    logic               touched;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               was_touched;
  } touch_result_t;

  typedef enum logic [0:0] {ROW_SAMPLE, ROW_REG} row_kind_t;

  // a row of the directed table: a sample set or a register write
  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;
    touch_sample_t         sample_set;
    bit                    fixed;
    touch_result_t         result;
  } stim_row_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // configuration port
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // sample channel
  logic             in_valid           = 1'b0;
  logic             in_ready;
  logic             in_pen_released    = 1'b0;
  logic [RAW_W-1:0] in_pressure_first  = '0;
  logic [RAW_W-1:0] in_pressure_second = '0;
  logic [RAW_W-1:0] in_x_sample_a      = '0;
  logic [RAW_W-1:0] in_x_sample_b      = '0;
  logic [RAW_W-1:0] in_x_sample_c      = '0;
  logic [RAW_W-1:0] in_y_sample_a      = '0;
  logic [RAW_W-1:0] in_y_sample_b      = '0;
  logic [RAW_W-1:0] in_y_sample_c      = '0;

  // result channel
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_touched;
  logic signed [COORD_W-1:0] out_pos_x;
  logic signed [COORD_W-1:0] out_pos_y;
  logic                      out_was_touched;

  // bench model state: register copy and previous touch flag
  cfg_t cfg_shadow;
  logic touched_shadow;

  // predictions waiting for their result transfer
  touch_result_t expected_results[$];

  int  mismatches     = 0;
  int  stall_cycles   = 0;
  int  hold_requests  = 0;
  int  holds_served   = 0;
  bit  quiet_tail     = 1'b0;

  touch_sample_filter_map_rotate_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_pen_released    (in_pen_released),
    .in_pressure_first  (in_pressure_first),
    .in_pressure_second (in_pressure_second),
    .in_x_sample_a      (in_x_sample_a),
    .in_x_sample_b      (in_x_sample_b),
    .in_x_sample_c      (in_x_sample_c),
    .in_y_sample_a      (in_y_sample_a),
    .in_y_sample_b      (in_y_sample_b),
    .in_y_sample_c      (in_y_sample_c),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_touched        (out_touched),
    .out_pos_x          (out_pos_x),
    .out_pos_y          (out_pos_y),
    .out_was_touched    (out_was_touched)
  );

  // 10 unit period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // bench model
  // --------------------------------------------------------------------------

  // mean of the two closest readings; ties go to (a,b), then (a,c)
  function automatic int closest_mean(int a, int b, int c);
    int dab, dac, dbc;
    dab = (a > b) ? a - b : b - a;
    dac = (a > c) ? a - c : c - a;
    dbc = (b > c) ? b - c : c - b;
    if (dab <= dac && dab <= dbc) return (a + b) >> 1;
    if (dac <= dab && dac <= dbc) return (a + c) >> 1;
    return (b + c) >> 1;
  endfunction

  // linear map of a raw reading onto 0..last, truncated toward zero, clamped
  function automatic int map_axis(int v, int lo, int hi, int last);
    longint m;
    int     floor_v, ceil_v;
    if (lo == hi) return 0;
    m = (longint'(v - lo) * longint'(last)) / longint'(hi - lo);
    // a zero panel size gives last = -1 and a clamp range of -1..0
    floor_v = (last < 0) ? last : 0;
    ceil_v  = (last < 0) ? 0 : last;
    if (m < floor_v) m = floor_v;
    if (m > ceil_v) m = ceil_v;
    return int'(m);
  endfunction

  function automatic touch_result_t predict_touch(touch_sample_t s, cfg_t c, logic prev);
    touch_result_t r;
    int            pressure, wl, hl, nx, ny, px, py;
    logic          hit;
    pressure = int'(s.pressure_first) + ADC_MAX - int'(s.pressure_second);
    hit = !s.pen_released && (pressure >= int'(c.min_pressure));
    px = -1;
    py = -1;
    if (hit) begin
      wl = int'(c.native_width) - 1;
      hl = int'(c.native_height) - 1;
      nx = map_axis(closest_mean(s.x_sample_a, s.x_sample_b, s.x_sample_c),
                    c.x_raw_min, c.x_raw_max, wl);
      ny = map_axis(closest_mean(s.y_sample_a, s.y_sample_b, s.y_sample_c),
                    c.y_raw_min, c.y_raw_max, hl);
      case (c.rotation)
        ROT_NONE: begin
          px = nx;
          py = ny;
        end
        ROT_90: begin
          px = hl - ny;
          py = nx;
        end
        ROT_180: begin
          px = wl - nx;
          py = hl - ny;
        end
        default: begin
          px = ny;
          py = wl - nx;
        end
      endcase
    end
    r.touched     = hit;
    r.pos_x       = px[COORD_W-1:0];
    r.pos_y       = py[COORD_W-1:0];
    r.was_touched = prev;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  function automatic stim_row_t sample_row(bit pen, int z1, int z2, int xa, int xb, int xc,
                                           int ya, int yb, int yc);
    stim_row_t r;
    r.kind                       = ROW_SAMPLE;
    r.reg_index                  = '0;
    r.reg_data                   = '0;
    r.sample_set.pen_released    = pen;
    r.sample_set.pressure_first  = z1[RAW_W-1:0];
    r.sample_set.pressure_second = z2[RAW_W-1:0];
    r.sample_set.x_sample_a      = xa[RAW_W-1:0];
    r.sample_set.x_sample_b      = xb[RAW_W-1:0];
    r.sample_set.x_sample_c      = xc[RAW_W-1:0];
    r.sample_set.y_sample_a      = ya[RAW_W-1:0];
    r.sample_set.y_sample_b      = yb[RAW_W-1:0];
    r.sample_set.y_sample_c      = yc[RAW_W-1:0];
    r.fixed                      = 1'b0;
    r.result                     = '{1'b0, '0, '0, 1'b0};
    return r;
  endfunction

  // same row with a result typed in by hand
  function automatic stim_row_t fixed_row(stim_row_t row, bit t, int x, int y, bit w);
    stim_row_t r;
    r        = row;
    r.fixed  = 1'b1;
    r.result = '{t, x[COORD_W-1:0], y[COORD_W-1:0], w};
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int data);
    stim_row_t r;
    r           = sample_row(1'b0, 0, 0, 0, 0, 0, 0, 0, 0);
    r.kind      = ROW_REG;
    r.reg_index = idx;
    r.reg_data  = data[CFG_DATA_W-1:0];
    return r;
  endfunction

  // raw calibration value, biased toward the ends of the range
  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return RAW_W'(ADC_MAX);
      default: return RAW_W'($urandom_range(0, ADC_MAX));
    endcase
  endfunction

  // panel size: mostly in range, sometimes 1, full or zero
  function automatic logic [RAW_W-1:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return RAW_W'(1);
      1:       return RAW_W'(ADC_MAX);
      2:       return '0;
      default: return RAW_W'($urandom_range(1, ADC_MAX));
    endcase
  endfunction

  // one reading of a noisy cluster around center
  function automatic logic [RAW_W-1:0] near_reading(int center, int spread);
    int v;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > ADC_MAX) v = ADC_MAX;
    return v[RAW_W-1:0];
  endfunction

  // sender gap: an occasional random idle gap, none when idling is off
  function automatic int pick_gap(bit no_idle);
    if (no_idle || $urandom_range(0, 4) != 0) return 0;
    return $urandom_range(1, 14);
  endfunction

  // register write on the cfg port, copied into the bench model with masking
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_MIN_PRESSURE:  cfg_shadow.min_pressure  = data[PRESS_W-1:0];
      REG_X_RAW_MIN:     cfg_shadow.x_raw_min     = data[RAW_W-1:0];
      REG_X_RAW_MAX:     cfg_shadow.x_raw_max     = data[RAW_W-1:0];
      REG_Y_RAW_MIN:     cfg_shadow.y_raw_min     = data[RAW_W-1:0];
      REG_Y_RAW_MAX:     cfg_shadow.y_raw_max     = data[RAW_W-1:0];
      REG_NATIVE_WIDTH:  cfg_shadow.native_width  = data[RAW_W-1:0];
      REG_NATIVE_HEIGHT: cfg_shadow.native_height = data[RAW_W-1:0];
      default:           cfg_shadow.rotation      = data[ROT_W-1:0];
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering and wait until every predicted result has transferred
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // offer one sample set, hold it until the transfer, then queue its result
  task automatic offer_sample(input touch_sample_t s, input int gap, input bit fixed,
                              input touch_result_t fixed_res);
    touch_result_t predicted;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_pen_released    <= s.pen_released;
    in_pressure_first  <= s.pressure_first;
    in_pressure_second <= s.pressure_second;
    in_x_sample_a      <= s.x_sample_a;
    in_x_sample_b      <= s.x_sample_b;
    in_x_sample_c      <= s.x_sample_c;
    in_y_sample_a      <= s.y_sample_a;
    in_y_sample_b      <= s.y_sample_b;
    in_y_sample_c      <= s.y_sample_c;
    do @(posedge clk); while (!in_ready);
    // the model always advances, even where the row carries its own result
    predicted      = predict_touch(s, cfg_shadow, touched_shadow);
    touched_shadow = predicted.touched;
    expected_results.push_back(fixed ? fixed_res : predicted);
  endtask

  // --------------------------------------------------------------------------
  // sender: reset, directed table, random phases, end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t             stim_table[$];
    touch_result_t         blank_result;
    touch_sample_t         s;
    logic [PRESS_W-1:0]    mp;
    logic [RAW_W-1:0]      xlo, xhi, ylo, yhi, wd, ht;
    logic [ROT_W-1:0]      rot;
    int                    p, n, kind, cx, cy, spread;
    bit                    no_idle;

    blank_result = '{1'b0, '0, '0, 1'b0};
    cfg_shadow = '{MIN_PRESSURE_RST, RAW_MIN_RST, RAW_MAX_RST, RAW_MIN_RST, RAW_MAX_RST,
                   NATIVE_WIDTH_RST, NATIVE_HEIGHT_RST, ROT_NONE};
    touched_shadow = 1'b0;

    // reset settings: pen up, then the full-scale corners
    stim_table.push_back(fixed_row(sample_row(1, 0, 0, 0, 0, 0, 0, 0, 0), 0, -1, -1, 0));
    stim_table.push_back(fixed_row(sample_row(0, 0, 4095, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0));
    stim_table.push_back(fixed_row(sample_row(0, 4095, 0, 4095, 4095, 4095,
                                              4095, 4095, 4095), 1, 319, 239, 1));
    stim_table.push_back(fixed_row(sample_row(1, 4095, 4095, 4095, 4095, 4095,
                                              4095, 4095, 4095), 0, -1, -1, 1));
    // closest pair ties, the (b,c) pair, odd sums
    stim_table.push_back(sample_row(0, 2000, 100, 100, 110, 90, 100, 200, 150));
    stim_table.push_back(sample_row(0, 3000, 50, 100, 200, 150, 0, 2000, 2001));
    stim_table.push_back(sample_row(0, 3000, 50, 1, 2, 4000, 4095, 4094, 0));
    // pressure threshold just above and at the pressure
    stim_table.push_back(reg_row(REG_MIN_PRESSURE, 4095));
    stim_table.push_back(fixed_row(sample_row(0, 100, 101, 2048, 2048, 2048,
                                              2048, 2048, 2048), 0, -1, -1, 1));
    stim_table.push_back(sample_row(0, 100, 100, 2048, 2048, 2048, 2048, 2048, 2048));
    // top threshold: even the largest pressure is too low
    stim_table.push_back(reg_row(REG_MIN_PRESSURE, 'h1FFF));
    stim_table.push_back(fixed_row(sample_row(0, 4095, 0, 10, 10, 10, 10, 10, 10),
                                   0, -1, -1, 1));
    // zero-width x range, inverted y range
    stim_table.push_back(reg_row(REG_MIN_PRESSURE, 0));
    stim_table.push_back(reg_row(REG_X_RAW_MIN, 1000));
    stim_table.push_back(reg_row(REG_X_RAW_MAX, 1000));
    stim_table.push_back(reg_row(REG_Y_RAW_MIN, 3000));
    stim_table.push_back(reg_row(REG_Y_RAW_MAX, 500));
    stim_table.push_back(sample_row(0, 4095, 0, 1000, 1000, 1000, 3000, 3000, 3000));
    stim_table.push_back(sample_row(0, 4095, 0, 0, 0, 0, 0, 0, 0));
    stim_table.push_back(sample_row(0, 4095, 0, 4095, 4095, 4095, 4095, 4095, 4095));
    // zero panel size; bit 12 of a 12-bit register is dropped
    stim_table.push_back(reg_row(REG_NATIVE_WIDTH, 0));
    stim_table.push_back(reg_row(REG_NATIVE_HEIGHT, 'h1000));
    stim_table.push_back(reg_row(REG_X_RAW_MIN, 0));
    stim_table.push_back(reg_row(REG_X_RAW_MAX, 4095));
    stim_table.push_back(reg_row(REG_Y_RAW_MIN, 0));
    stim_table.push_back(reg_row(REG_Y_RAW_MAX, 4095));
    stim_table.push_back(sample_row(0, 4095, 0, 4095, 4095, 4095, 4095, 4095, 4095));
    stim_table.push_back(sample_row(0, 4095, 0, 2000, 2000, 2000, 2000, 2000, 2000));
    stim_table.push_back(reg_row(REG_ROTATION, ROT_90));
    stim_table.push_back(sample_row(0, 4095, 0, 4095, 4095, 4095, 0, 0, 0));
    stim_table.push_back(reg_row(REG_ROTATION, ROT_180));
    stim_table.push_back(sample_row(0, 4095, 0, 4095, 4095, 4095, 0, 0, 0));
    // upper bits of the rotation write are dropped, leaving a 270 turn
    stim_table.push_back(reg_row(REG_ROTATION, 'h1FFF));
    stim_table.push_back(sample_row(0, 4095, 0, 0, 0, 0, 4095, 4095, 4095));
    // all turns on a normal panel
    stim_table.push_back(reg_row(REG_NATIVE_WIDTH, 'h1000 | 320));
    stim_table.push_back(reg_row(REG_NATIVE_HEIGHT, 240));
    stim_table.push_back(sample_row(0, 3000, 1000, 300, 310, 290, 3500, 3490, 3600));
    stim_table.push_back(reg_row(REG_ROTATION, ROT_90));
    stim_table.push_back(sample_row(0, 3000, 1000, 300, 310, 290, 3500, 3490, 3600));
    stim_table.push_back(reg_row(REG_ROTATION, ROT_180));
    stim_table.push_back(sample_row(0, 3000, 1000, 300, 310, 290, 3500, 3490, 3600));
    stim_table.push_back(reg_row(REG_ROTATION, ROT_NONE));
    stim_table.push_back(sample_row(0, 0, 0, 4095, 0, 2048, 0, 4095, 2047));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed table walk
    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_REG) begin
        settle_block();
        write_reg(stim_table[i].reg_index, stim_table[i].reg_data);
      end else begin
        offer_sample(stim_table[i].sample_set, pick_gap(1'b0), stim_table[i].fixed,
                     stim_table[i].result);
      end
    end

    // random phases, each starting from an idle block with a fresh setting
    for (p = 0; p < NUM_PHASES; p++) begin
      settle_block();
      case (p)
        0: begin
          mp = '0;
          xlo = '0;
          xhi = RAW_W'(ADC_MAX);
          ylo = RAW_W'(ADC_MAX);
          yhi = '0;
          wd = RAW_W'(ADC_MAX);
          ht = RAW_W'(1);
          rot = ROT_90;
        end
        1: begin
          mp = PRESS_W'(4095);
          xlo = RAW_W'(ADC_MAX);
          xhi = '0;
          ylo = '0;
          yhi = RAW_W'(ADC_MAX);
          wd = RAW_W'(1);
          ht = RAW_W'(ADC_MAX);
          rot = ROT_270;
        end
        default: begin
          case ($urandom_range(0, 7))
            0:       mp = '0;
            1:       mp = '1;
            default: mp = PRESS_W'($urandom_range(0, 6000));
          endcase
          xlo = pick_raw();
          xhi = pick_raw();
          ylo = pick_raw();
          yhi = pick_raw();
          if ($urandom_range(0, 7) == 0) xhi = xlo;
          if ($urandom_range(0, 7) == 0) yhi = ylo;
          wd = pick_size();
          ht = pick_size();
          rot = ROT_W'($urandom_range(0, 3));
        end
      endcase
      // spare upper data bits go out random on the narrower registers
      write_reg(REG_MIN_PRESSURE, mp);
      write_reg(REG_X_RAW_MIN, {1'($urandom_range(0, 1)), xlo});
      write_reg(REG_X_RAW_MAX, {1'($urandom_range(0, 1)), xhi});
      write_reg(REG_Y_RAW_MIN, {1'($urandom_range(0, 1)), ylo});
      write_reg(REG_Y_RAW_MAX, {1'($urandom_range(0, 1)), yhi});
      write_reg(REG_NATIVE_WIDTH, {1'($urandom_range(0, 1)), wd});
      write_reg(REG_NATIVE_HEIGHT, {1'($urandom_range(0, 1)), ht});
      write_reg(REG_ROTATION, {11'($urandom), rot});

      // last phase runs with no idling on either side
      quiet_tail = (p == NUM_PHASES - 1);
      no_idle = quiet_tail || (p % 4 == 2);

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // receiver holds off while the sender keeps offering
        if (p == HOLD_PHASE && n == 10) hold_requests++;
        // sender pauses until every result is in
        if (p == PAUSE_PHASE && n == 50) settle_block();

        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          // pen down, firm press, three readings clustered per axis
          cx = $urandom_range(0, ADC_MAX);
          cy = $urandom_range(0, ADC_MAX);
          spread = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 48);
          s.pen_released    = 1'b0;
          s.pressure_first  = RAW_W'($urandom_range(2048, ADC_MAX));
          s.pressure_second = RAW_W'($urandom_range(0, 2047));
          s.x_sample_a      = near_reading(cx, spread);
          s.x_sample_b      = near_reading(cx, spread);
          s.x_sample_c      = near_reading(cx, spread);
          s.y_sample_a      = near_reading(cy, spread);
          s.y_sample_b      = near_reading(cy, spread);
          s.y_sample_c      = near_reading(cy, spread);
          // one stray reading on an axis
          if (kind == 6) begin
            case ($urandom_range(0, 2))
              0:       s.x_sample_a = RAW_W'($urandom_range(0, ADC_MAX));
              1:       s.y_sample_b = RAW_W'($urandom_range(0, ADC_MAX));
              default: s.x_sample_c = RAW_W'($urandom_range(0, ADC_MAX));
            endcase
          end
        end else begin
          // noise: every field random, pen up more often
          s.pen_released    = (kind == 9) ? 1'b1 : 1'($urandom_range(0, 1));
          s.pressure_first  = RAW_W'($urandom_range(0, ADC_MAX));
          s.pressure_second = RAW_W'($urandom_range(0, ADC_MAX));
          s.x_sample_a      = RAW_W'($urandom_range(0, ADC_MAX));
          s.x_sample_b      = RAW_W'($urandom_range(0, ADC_MAX));
          s.x_sample_c      = RAW_W'($urandom_range(0, ADC_MAX));
          s.y_sample_a      = RAW_W'($urandom_range(0, ADC_MAX));
          s.y_sample_b      = RAW_W'($urandom_range(0, ADC_MAX));
          s.y_sample_c      = RAW_W'($urandom_range(0, ADC_MAX));
        end
        offer_sample(s, pick_gap(no_idle), 1'b0, blank_result);
      end
    end

    // let the last results drain, then a quiet stretch for stray transfers
    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // receiver: random ready bursts, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int span;
    @(posedge clk);
    forever begin
      if (holds_served < hold_requests) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (quiet_tail || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        if (quiet_tail) span = 1;
        else if ($urandom_range(0, 9) == 0) span = $urandom_range(100, 300);
        else span = $urandom_range(1, 40);
        repeat (span) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // result check: each transfer against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    touch_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: result transfer with nothing expected: touched=%0d x=%0d y=%0d was=%0d",
                   $time, out_touched, out_pos_x, out_pos_y, out_was_touched);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_touched !== want.touched || out_pos_x !== want.pos_x ||
            out_pos_y !== want.pos_y || out_was_touched !== want.was_touched) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: mismatch: expected touched=%0d x=%0d y=%0d was=%0d, got %0d %0d %0d %0d",
                     $time, want.touched, $signed(want.pos_x), $signed(want.pos_y),
                     want.was_touched, out_touched, out_pos_x, out_pos_y, out_was_touched);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: cycles in a row without any transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
rtl/tsfmr_pkg.sv
rtl/tsfmr_div.sv
rtl/touch_sample_filter_map_rotate_core.sv
tb/touch_sample_filter_map_rotate_core_test.sv
